>>> rtl/stm_pkg.sv
package stm_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;
   localparam int ADDR_W          = 32;
   localparam int STATUS_W        = 3;
   localparam int SLOT_W          = 5;
   localparam int FUNC_W          = 2;
   localparam int REQ_TDATA_W     = 64;
   localparam int RSP_TDATA_W     = 72;

   // classful network checks
   localparam logic [ADDR_W-1:0] CLASS_TOP3_MASK = 32'hE000_0000;
   localparam logic [ADDR_W-1:0] CLASS_C_TOP     = 32'hC000_0000;
   localparam logic [ADDR_W-1:0] CLASS_C_MIN     = 32'hFFFF_FF00;
   localparam logic [ADDR_W-1:0] CLASS_B_MIN     = 32'hFFFF_0000;
   localparam logic [ADDR_W-1:0] CLASS_A_MIN     = 32'hFF00_0000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE     = 3'd0,
      STAT_INVALID  = 3'd1,
      STAT_COVERED  = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] mask;
   } entry_type;

   typedef struct packed {
      logic contains;
      logic exact;
      logic net_ok;
   } cmp_result_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_set;
   } tbl_cmd_type;

endpackage

>>> rtl/subnet_table_match.sv
// subnet_table_match: table of ipv4 networks (address + mask), TABLE_DEPTH slots
//
// req channel: one beat per command. req_tuser carries the operation
// (add, lookup host, remove, list), req_tdata the address and the mask.
// rsp channel: result beats with status, entry address, mask and slot;
// rsp_tlast marks the final beat of a command. add, lookup and remove give
// one beat; list gives one beat per valid entry (at most 32), or one
// not-found beat when the table is empty.
//
// timing: the table sits in a memory with separate read and write ports,
// read one slot per cycle by the sequencer (the list scan pauses while
// the output beat is stalled) and checked by one shared compare unit. a
// command ends its scan early when a match is found; add and remove write back in
// the cycle the result is loaded. list streams at most one beat per cycle.
// req_tready is low from accept until the command's last beat is loaded,
// so a new command is not accepted before the last one is through.
//
// reset (synchronous, active high) clears all slot valid bits at once and
// drops rsp_tvalid. a stalled receiver holds the output beat; the list scan
// pauses until the beat is taken.
module subnet_table_match import stm_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address[31:0], net_mask_in[63:32]
   input  logic [FUNC_W-1:0]      req_tuser,   // func[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // status[2:0], entry_address[34:3],
                                               // entry_mask[66:35], entry_slot[71:67]
   output logic                   rsp_tlast    // last
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ADDR_W-1:0]      key_addr;
   logic [ADDR_W-1:0]      key_mask;
   cmp_result_type         cmp;
   tbl_cmd_type            tbl_cmd;
   logic [IW-1:0]          tbl_rd_idx;
   logic [IW-1:0]          tbl_wr_idx;
   entry_type              tbl_wr_entry;
   entry_type              tbl_rd_entry;
   logic [TABLE_DEPTH-1:0] valid_vec;
   status_type             rsp_status;
   entry_type              rsp_entry;
   logic [SLOT_W-1:0]      rsp_slot;

   // sequencer: command capture, slot scan, output register
   stm_seq #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_func     (func_type'(req_tuser)),
      .req_addr     (req_tdata[31:0]),
      .req_mask     (req_tdata[63:32]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_entry    (rsp_entry),
      .rsp_slot     (rsp_slot),
      .rsp_last     (rsp_tlast),
      .key_addr     (key_addr),
      .key_mask     (key_mask),
      .cmp          (cmp),
      .tbl_cmd      (tbl_cmd),
      .tbl_rd_idx   (tbl_rd_idx),
      .tbl_wr_idx   (tbl_wr_idx),
      .tbl_wr_entry (tbl_wr_entry),
      .tbl_rd_entry (tbl_rd_entry),
      .valid_vec    (valid_vec)
   );

   // shared compare unit, fed by the slot just read
   stm_cmp u_cmp (
      .key_addr (key_addr),
      .key_mask (key_mask),
      .entry    (tbl_rd_entry),
      .result   (cmp)
   );

   // network/mask storage with per-slot valid bits
   stm_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tbl_cmd),
      .rd_idx    (tbl_rd_idx),
      .wr_idx    (tbl_wr_idx),
      .wr_entry  (tbl_wr_entry),
      .rd_entry  (tbl_rd_entry),
      .valid_vec (valid_vec)
   );

   assign rsp_tdata = {rsp_slot, rsp_entry.mask, rsp_entry.net, rsp_status};

endmodule

>>> rtl/stm_table.sv
module stm_table import stm_pkg::*; #(
   parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_cmd_type            cmd,
   input  logic [IW-1:0]          rd_idx,
   input  logic [IW-1:0]          wr_idx,
   input  entry_type              wr_entry,
   output entry_type              rd_entry,
   output logic [TABLE_DEPTH-1:0] valid_vec
);

   entry_type              table_mem [TABLE_DEPTH];
   entry_type              rd_entry_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;

   // entry contents are don't-care while its valid bit is low
   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_set) begin
         table_mem[wr_idx] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= table_mem[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_idx] = cmd.wr_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_entry  = rd_entry_ff;
   assign valid_vec = valid_ff;

endmodule

>>> rtl/stm_cmp.sv
module stm_cmp import stm_pkg::*; (
   input  logic [ADDR_W-1:0] key_addr,
   input  logic [ADDR_W-1:0] key_mask,
   input  entry_type         entry,
   output cmp_result_type    result
);

   logic class_ok;

   // mask is compared as a number, not checked for contiguity
   always_comb begin
      if ((key_addr & CLASS_TOP3_MASK) == CLASS_TOP3_MASK) begin
         class_ok = 1'b0;
      end else if ((key_addr & CLASS_TOP3_MASK) == CLASS_C_TOP) begin
         class_ok = (key_mask >= CLASS_C_MIN);
      end else if (key_addr[ADDR_W-1]) begin
         class_ok = (key_mask >= CLASS_B_MIN);
      end else begin
         class_ok = (key_mask >= CLASS_A_MIN);
      end
   end

   assign result.net_ok   = ((key_addr & key_mask) == key_addr) && class_ok;
   assign result.contains = ((key_addr & entry.mask) == entry.net);
   assign result.exact    = (entry.net == key_addr) && (entry.mask == key_mask);

endmodule

>>> rtl/stm_seq.sv
module stm_seq import stm_pkg::*; #(
   parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  func_type               req_func,
   input  logic [ADDR_W-1:0]      req_addr,
   input  logic [ADDR_W-1:0]      req_mask,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output status_type             rsp_status,
   output entry_type              rsp_entry,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_last,
   output logic [ADDR_W-1:0]      key_addr,
   output logic [ADDR_W-1:0]      key_mask,
   input  cmp_result_type         cmp,
   output tbl_cmd_type            tbl_cmd,
   output logic [IW-1:0]          tbl_rd_idx,
   output logic [IW-1:0]          tbl_wr_idx,
   output entry_type              tbl_wr_entry,
   input  entry_type              tbl_rd_entry,
   input  logic [TABLE_DEPTH-1:0] valid_vec
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = $clog2(MAX_RESULTS);

   state_type         state_ff, state_in;
   func_type          op_ff, op_in;
   logic [ADDR_W-1:0] key_addr_ff, key_addr_in;
   logic [ADDR_W-1:0] key_mask_ff, key_mask_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              s1_vld_ff, s1_vld_in;
   logic [IW-1:0]     s1_slot_ff, s1_slot_in;
   logic              free_found_ff, free_found_in;
   logic [IW-1:0]     free_slot_ff, free_slot_in;
   logic [LW-1:0]     list_cnt_ff, list_cnt_in;
   status_type        res_status_ff, res_status_in;
   entry_type         res_entry_ff, res_entry_in;
   logic [IW-1:0]     res_slot_ff, res_slot_in;
   logic              res_wr_ff, res_wr_in;
   logic              res_set_ff, res_set_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              ent_ok;
   logic              hit;
   logic              scan_end;
   logic              more_valid;
   logic              list_last;
   logic              stall;
   logic              issue;
   logic [TABLE_DEPTH:0] hi_vec;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ent_ok   = valid_vec[s1_slot_ff];
   assign scan_end = s1_vld_ff && (s1_slot_ff == IW'(TABLE_DEPTH - 1));

   // any valid slot above the one in the compare stage
   assign hi_vec     = {1'b0, valid_vec} >> s1_slot_ff;
   assign more_valid = |hi_vec[TABLE_DEPTH:1];
   assign list_last  = !more_valid || (list_cnt_ff == LW'(MAX_RESULTS - 1));

   always_comb begin
      unique case (op_ff)
         FUNC_ADD, FUNC_LOOKUP: hit = s1_vld_ff && ent_ok && cmp.contains;
         FUNC_REMOVE:           hit = s1_vld_ff && ent_ok && cmp.exact;
         FUNC_LIST:             hit = s1_vld_ff && ent_ok;
         default:               hit = 1'b0;
      endcase
   end

   assign stall = (op_ff == FUNC_LIST) && hit && !out_free;
   assign issue = (rd_idx_ff < CW'(TABLE_DEPTH)) && !stall;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_addr_in   = key_addr_ff;
      key_mask_in   = key_mask_ff;
      rd_idx_in     = rd_idx_ff;
      s1_vld_in     = s1_vld_ff;
      s1_slot_in    = s1_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      list_cnt_in   = list_cnt_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_slot_in   = res_slot_ff;
      res_wr_in     = res_wr_ff;
      res_set_in    = res_set_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      tbl_cmd       = '0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = req_func;
               key_addr_in   = req_addr;
               key_mask_in   = req_mask;
               rd_idx_in     = '0;
               s1_vld_in     = 1'b0;
               free_found_in = 1'b0;
               list_cnt_in   = '0;
               res_wr_in     = 1'b0;
               res_set_in    = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (op_ff == FUNC_ADD && !cmp.net_ok) begin
               res_status_in = STAT_INVALID;
               res_entry_in  = '0;
               res_slot_in   = '0;
               state_in      = ST_FINISH;
            end else if (!stall) begin
               // read pipeline: address now, compare next cycle
               tbl_cmd.rd_en = issue;
               if (issue) begin
                  rd_idx_in = rd_idx_ff + CW'(1);
               end
               s1_vld_in  = issue;
               s1_slot_in = rd_idx_ff[IW-1:0];

               if (s1_vld_ff && !ent_ok && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = s1_slot_ff;
               end

               if (hit) begin
                  if (op_ff == FUNC_LIST) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DONE;
                     rsp_entry_in  = tbl_rd_entry;
                     rsp_slot_in   = SLOT_W'(s1_slot_ff);
                     rsp_last_in   = list_last;
                     list_cnt_in   = list_cnt_ff + LW'(1);
                     if (list_last) begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     res_status_in = (op_ff == FUNC_ADD) ? STAT_COVERED : STAT_DONE;
                     res_entry_in  = tbl_rd_entry;
                     res_slot_in   = s1_slot_ff;
                     res_wr_in     = (op_ff == FUNC_REMOVE);
                     res_set_in    = 1'b0;
                     state_in      = ST_FINISH;
                  end
               end else if (scan_end) begin
                  res_status_in = STAT_NOTFOUND;
                  res_entry_in  = '0;
                  res_slot_in   = '0;
                  if (op_ff == FUNC_ADD) begin
                     if (free_found_ff || !ent_ok) begin
                        res_status_in    = STAT_DONE;
                        res_entry_in.net  = key_addr_ff;
                        res_entry_in.mask = key_mask_ff;
                        res_slot_in      = free_found_ff ? free_slot_ff : s1_slot_ff;
                        res_wr_in        = 1'b1;
                        res_set_in       = 1'b1;
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               rsp_last_in   = 1'b1;
               tbl_cmd.wr_en  = res_wr_ff;
               tbl_cmd.wr_set = res_set_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_addr_ff   <= key_addr_in;
      key_mask_ff   <= key_mask_in;
      rd_idx_ff     <= rd_idx_in;
      s1_slot_ff    <= s1_slot_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      list_cnt_ff   <= list_cnt_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_slot_ff   <= res_slot_in;
      res_wr_ff     <= res_wr_in;
      res_set_ff    <= res_set_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_entry    = rsp_entry_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;
   assign key_addr     = key_addr_ff;
   assign key_mask     = key_mask_ff;
   assign tbl_rd_idx   = rd_idx_ff[IW-1:0];
   assign tbl_wr_idx   = res_slot_ff;
   assign tbl_wr_entry = res_entry_ff;

endmodule

>>> rtl/stm_checker.sv
module stm_checker import stm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // busy while a command is scanned
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted during scan");

   // only list beats may be non-final, and they always report done
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[2:0] == STAT_DONE)
      else $error("non-final beat without done status");

   // failure results carry an all-zero entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == STAT_INVALID || rsp_tdata[2:0] == STAT_FULL
                     || rsp_tdata[2:0] == STAT_NOTFOUND)
      |-> rsp_tdata[RSP_TDATA_W-1:STATUS_W] == '0)
      else $error("failure beat with nonzero entry");

endmodule

bind subnet_table_match stm_checker u_stm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> sim/tb.sv
module tb;
   import stm_pkg::*;

   localparam int TBL_SLOTS    = TABLE_DEPTH_DEF;
   localparam int RANDOM_CMDS  = 420;
   localparam int DRAIN_CYCLES = TABLE_DEPTH_DEF + 8;

   typedef struct {
      func_type    func;
      logic [31:0] addr;
      logic [31:0] mask;
   } subnet_cmd_type;

   typedef struct {
      status_type  status;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [4:0]  slot;
      logic        last;
   } match_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // address[31:0], net_mask_in[63:32]
   logic [FUNC_W-1:0]      req_tuser  = '0;   // func[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // status[2:0], entry_address[34:3],
                                              // entry_mask[66:35], entry_slot[71:67]
   logic                   rsp_tlast;

   subnet_table_match DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // commands waiting to be driven, and beats the table should answer with
   subnet_cmd_type pending_cmds[$];
   match_beat_type expected_beats[$];

   // shadow copy of the network table
   logic [31:0] shadow_net [TBL_SLOTS];
   logic [31:0] shadow_mask[TBL_SLOTS];

   logic [31:0] cycle_count = '0;
   int          fail_count  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ------------------------------------------------------------------
   // table predictor
   // ------------------------------------------------------------------

   // proper classful network: host bits clear, class a/b/c, mask at least
   // the class default (compared as a number, so gappy masks may pass)
   function automatic bit is_classful(logic [31:0] a, logic [31:0] m);
      if ((a & m) != a) return 1'b0;
      if (a[31:29] == 3'b111) return 1'b0;
      if (a[31:29] == 3'b110) return m >= CLASS_C_MIN;
      if (a[31:30] == 2'b10) return m >= CLASS_B_MIN;
      return m >= CLASS_A_MIN;
   endfunction

   // first occupied slot whose network holds the address, -1 if none
   function automatic int find_owner(logic [31:0] a);
      for (int i = 0; i < TBL_SLOTS; i++) begin
         if (shadow_mask[i] != '0 && (a & shadow_mask[i]) == shadow_net[i]) return i;
      end
      return -1;
   endfunction

   function automatic void push_beat(status_type st, logic [31:0] a, logic [31:0] m,
                                     int slot, logic last);
      match_beat_type b;
      b.status = st;
      b.addr   = a;
      b.mask   = m;
      b.slot   = slot[4:0];
      b.last   = last;
      expected_beats.push_back(b);
   endfunction

   function automatic void predict_subnet_cmd(subnet_cmd_type c);
      int hit;
      int listed;
      hit    = -1;
      listed = 0;
      case (c.func)
         FUNC_ADD: begin
            if (!is_classful(c.addr, c.mask)) begin
               push_beat(STAT_INVALID, '0, '0, 0, 1'b1);
               return;
            end
            hit = find_owner(c.addr);
            if (hit >= 0) begin
               push_beat(STAT_COVERED, shadow_net[hit], shadow_mask[hit], hit, 1'b1);
               return;
            end
            for (int i = 0; i < TBL_SLOTS; i++) begin
               if (shadow_mask[i] == '0) begin
                  shadow_net[i]  = c.addr;
                  shadow_mask[i] = c.mask;
                  push_beat(STAT_DONE, c.addr, c.mask, i, 1'b1);
                  return;
               end
            end
            push_beat(STAT_FULL, '0, '0, 0, 1'b1);
         end
         FUNC_LOOKUP: begin
            hit = find_owner(c.addr);
            if (hit >= 0) push_beat(STAT_DONE, shadow_net[hit], shadow_mask[hit], hit, 1'b1);
            else          push_beat(STAT_NOTFOUND, '0, '0, 0, 1'b1);
         end
         FUNC_REMOVE: begin
            // only an exact address and mask match counts
            for (int i = 0; i < TBL_SLOTS; i++) begin
               if (shadow_mask[i] != '0 && shadow_net[i] == c.addr &&
                   shadow_mask[i] == c.mask) begin
                  push_beat(STAT_DONE, c.addr, c.mask, i, 1'b1);
                  shadow_net[i]  = '0;
                  shadow_mask[i] = '0;
                  return;
               end
            end
            push_beat(STAT_NOTFOUND, '0, '0, 0, 1'b1);
         end
         default: begin
            for (int i = 0; i < TBL_SLOTS && listed < MAX_RESULTS; i++) begin
               if (shadow_mask[i] != '0) begin
                  push_beat(STAT_DONE, shadow_net[i], shadow_mask[i], i, 1'b0);
                  listed++;
               end
            end
            if (listed == 0) push_beat(STAT_NOTFOUND, '0, '0, 0, 1'b1);
            else expected_beats[expected_beats.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // random gap: calm windows with none at all, otherwise mostly short
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (cycle_count[10:9] == 2'b00) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_cmd(func_type f, logic [31:0] a, logic [31:0] m);
      subnet_cmd_type c;
      c.func = f;
      c.addr = a;
      c.mask = m;
      pending_cmds.push_back(c);
   endfunction

   // random well-formed classful network, now and then with a gappy mask
   function automatic subnet_cmd_type make_network();
      subnet_cmd_type c;
      int             cls;
      int             plen;
      cls = $urandom_range(0, 9);
      if (cls < 6)      plen = $urandom_range(24, 32);
      else if (cls < 8) plen = $urandom_range(16, 32);
      else              plen = $urandom_range(8, 32);
      c.func = FUNC_ADD;
      c.mask = ~(32'hFFFF_FFFF >> plen);
      if (plen == 32) c.mask = 32'hFFFF_FFFF;
      if ($urandom_range(0, 9) == 0) c.mask = c.mask | ($urandom & ~c.mask);
      c.addr = $urandom & c.mask;
      if (cls < 6)      c.addr[31:29] = 3'b110;
      else if (cls < 8) c.addr[31:30] = 2'b10;
      else              c.addr[31]    = 1'b0;
      return c;
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   subnet_cmd_type cur_cmd;
   int             req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // the beat on the bus was taken at this edge
         if (req_tvalid && req_tready) predict_subnet_cmd(cur_cmd);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               cur_cmd    = pending_cmds.pop_front();
               req_tdata  <= {cur_cmd.mask, cur_cmd.addr};
               req_tuser  <= cur_cmd.func;
               req_tvalid <= 1'b1;
               req_gap    = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   match_beat_type want_beat;
   int             rsp_stall = 0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("status: expected no beat, actual %0d", rsp_tdata[2:0]);
            fail_count++;
         end else begin
            want_beat = expected_beats.pop_front();
            check_field("status", 32'(want_beat.status), 32'(rsp_tdata[2:0]));
            check_field("entry_address", want_beat.addr, rsp_tdata[34:3]);
            check_field("entry_mask", want_beat.mask, rsp_tdata[66:35]);
            check_field("entry_slot", 32'(want_beat.slot), 32'(rsp_tdata[71:67]));
            check_field("last", 32'(want_beat.last), 32'(rsp_tlast));
         end
         rsp_stall = pick_gap();
      end
      if (rsp_stall > 0) begin
         rsp_stall  = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   subnet_cmd_type net_pool[$];

   initial begin
      subnet_cmd_type c;
      int             pos;
      int             r;
      int             k;

      // directed: empty table, each class, each refusal but a full table, each func
      queue_cmd(FUNC_LIST,   32'h0000_0000, 32'h0000_0000);
      queue_cmd(FUNC_LOOKUP, 32'h0A01_0203, 32'h0000_0000);
      queue_cmd(FUNC_REMOVE, 32'h0A00_0000, 32'hFF00_0000);
      queue_cmd(FUNC_ADD,    32'h0A00_0001, 32'hFF00_0000);  // host bits set
      queue_cmd(FUNC_ADD,    32'hE000_0000, 32'hFFFF_FFFF);  // class d
      queue_cmd(FUNC_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);  // class e
      queue_cmd(FUNC_ADD,    32'hC0A8_0000, 32'hFFFF_0000);  // class c, short mask
      queue_cmd(FUNC_ADD,    32'h8000_0000, 32'hFF00_0000);  // class b, short mask
      queue_cmd(FUNC_ADD,    32'h0000_0000, 32'h0000_0000);  // zero mask
      queue_cmd(FUNC_ADD,    32'h0A00_0000, 32'hFF00_0000);
      queue_cmd(FUNC_ADD,    32'h8000_0000, 32'hFFFF_0000);
      queue_cmd(FUNC_ADD,    32'hC0A8_0100, 32'hFFFF_FF00);
      queue_cmd(FUNC_ADD,    32'h0B00_0000, 32'hFF00_FF00);  // gappy but large enough
      queue_cmd(FUNC_ADD,    32'hDFFF_FFFF, 32'hFFFF_FFFF);  // class c host route
      queue_cmd(FUNC_ADD,    32'h0000_0000, 32'hFF00_0000);  // net zero, class a
      queue_cmd(FUNC_ADD,    32'h0A01_0000, 32'hFFFF_0000);  // inside 10/8
      queue_cmd(FUNC_LOOKUP, 32'h0A12_3456, 32'h0000_0000);
      queue_cmd(FUNC_LOOKUP, 32'h7F00_0001, 32'hFFFF_FFFF);
      queue_cmd(FUNC_LIST,   32'h0000_0000, 32'h0000_0000);
      queue_cmd(FUNC_REMOVE, 32'h0A01_0000, 32'hFFFF_0000);  // contained, not exact
      queue_cmd(FUNC_REMOVE, 32'h0A00_0000, 32'hFF00_0000);
      queue_cmd(FUNC_LOOKUP, 32'h0A12_3456, 32'h0000_0000);
      queue_cmd(FUNC_ADD,    32'h0A01_0000, 32'hFFFF_0000);  // reuses the freed slot
      queue_cmd(FUNC_LIST,   32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random: fill and drain rounds so the table runs full and empties
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         pos = n % 100;
         r   = $urandom_range(0, 99);
         if (r < 8) begin
            // noise over the whole field space
            c.func = func_type'($urandom_range(0, 3));
            c.addr = $urandom;
            c.mask = $urandom;
            pending_cmds.push_back(c);
         end else if (r < 12) begin
            queue_cmd(FUNC_LIST, $urandom, $urandom);
         end else if ((pos < 50 && r < 75) || (pos >= 50 && r < 30)) begin
            k = $urandom_range(0, 9);
            if (k == 0 && net_pool.size() != 0) begin
               // host route inside a known network, usually refused as covered
               c = net_pool[$urandom_range(0, net_pool.size() - 1)];
               queue_cmd(FUNC_ADD, c.addr | ($urandom & ~c.mask), 32'hFFFF_FFFF);
            end else if (k == 1 && net_pool.size() != 0) begin
               pending_cmds.push_back(net_pool[$urandom_range(0, net_pool.size() - 1)]);
            end else begin
               c = make_network();
               net_pool.push_back(c);
               pending_cmds.push_back(c);
            end
         end else if ((pos < 50 && r < 90) || (pos >= 50 && r < 45)) begin
            if (net_pool.size() != 0 && $urandom_range(0, 4) != 0) begin
               c = net_pool[$urandom_range(0, net_pool.size() - 1)];
               queue_cmd(FUNC_LOOKUP, c.addr | ($urandom & ~c.mask), $urandom);
            end else begin
               queue_cmd(FUNC_LOOKUP, $urandom, $urandom);
            end
         end else begin
            if (net_pool.size() != 0) begin
               k = $urandom_range(0, net_pool.size() - 1);
               c = net_pool[k];
               c.func = FUNC_REMOVE;
               if ($urandom_range(0, 6) == 0) begin
                  // widened mask: the entry still contains it but is no exact match
                  c.mask = c.mask | (32'h1 << $urandom_range(0, 7));
               end else begin
                  net_pool.delete(k);
               end
               pending_cmds.push_back(c);
            end else begin
               queue_cmd(FUNC_REMOVE, $urandom, $urandom);
            end
         end
      end

      for (int i = 0; i < TBL_SLOTS; i++) begin
         shadow_net[i]  = '0;
         shadow_mask[i] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("subnet_table_match: match");
      end else begin
         $display("subnet_table_match: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("subnet_table_match: mismatch");
      $finish;
   end

endmodule
